>>> sv/eth_vlan_ipv4_header_checker_defines.svh
// Assertion macros shared by the checker of the Ethernet/VLAN/IPv4 header checker.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ETH_VLAN_IPV4_HEADER_CHECKER_DEFINES_SVH
`define ETH_VLAN_IPV4_HEADER_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("evic assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EVIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("evic assertion failed");

`endif

>>> sv/evic_pkg.sv
// Package of the Ethernet/VLAN/IPv4 header checker: header constants and status codes.
// Used by the top level and by its assertion checker; depends on nothing.
`timescale 1ns / 1ps

package evic_pkg;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;

  localparam logic [4:0] OFF_PLAIN = 5'd14;
  localparam logic [4:0] OFF_VLAN  = 5'd18;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] MIN_IHL    = 4'd5;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Byte positions of the two EtherType fields.
  localparam logic [15:0] POS_OUTER_HI = 16'd12;
  localparam logic [15:0] POS_OUTER_LO = 16'd13;
  localparam logic [15:0] POS_INNER_HI = 16'd16;
  localparam logic [15:0] POS_INNER_LO = 16'd17;

  // Offsets inside the IPv4 header.
  localparam logic [15:0] REL_TOTLEN_HI = 16'd2;
  localparam logic [15:0] REL_TOTLEN_LO = 16'd3;
  localparam logic [15:0] REL_PROTO     = 16'd9;
  localparam logic [16:0] IP_HDR_MIN    = 17'd20;

  localparam logic [16:0] ETH_HDR_LEN  = 17'd14;
  localparam logic [16:0] VLAN_HDR_END = 17'd18;

  localparam logic [15:0] IDX_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LEN_MISMATCH = 2'd1,
    ST_NOT_IPV4     = 2'd2,
    ST_BAD_IP       = 2'd3
  } status_e;

endpackage

>>> sv/eth_vlan_ipv4_header_checker.sv
// Ethernet / 802.1Q / IPv4 header checker: one frame byte per transfer, one result per frame.
// Depends on evic_pkg.
// The result of a frame is computed as its last byte leaves the input register, and it is
// held in the output register until it transfers.
// Throughput: one byte per cycle unless stalled; the input is stalled only while the input
// register holds the last byte of a frame and a finished result is held back by out_stall_i.
// Reset (rst_ni, asynchronous, active low) clears the byte count, the captured header
// fields and both valid flags.
`timescale 1ns / 1ps

module eth_vlan_ipv4_header_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0]  pkt_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] cap_len_i,
  input  logic [15:0] wire_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  ip_offset_o,
  output logic        is_udp_o,
  output logic [6:0]  udp_offset_o
);

  // Input register.
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic [15:0] s1_cap_q;
  logic [15:0] s1_wire_q;

  // Frame state.
  logic [15:0] idx_q, idx_d;
  logic [15:0] outer_q, outer_d;
  logic [15:0] inner_q, inner_d;
  logic        vlan_q, vlan_d;
  logic [7:0]  ver_ihl_q, ver_ihl_d;
  logic [15:0] totlen_q, totlen_d;
  logic [7:0]  proto_q, proto_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q;
  logic [4:0]  ip_off_q;
  logic        udp_q;
  logic [6:0]  udp_off_q;

  logic        in_accept;
  logic        out_ready;
  logic        s1_go;
  logic        res_load;

  // Captured values including the current byte, used for the check on the last byte.
  logic [15:0] cap_outer, cap_inner, cap_totlen;
  logic [7:0]  cap_ver_ihl, cap_proto;
  logic        cap_vlan;
  logic [15:0] hdr_off;
  logic [15:0] rel;
  logic [16:0] n;
  logic [4:0]  eval_off;
  logic [15:0] room;
  logic [15:0] ihl_x4;
  logic [3:0]  ihl;
  logic [3:0]  ver;
  evic_pkg::status_e status_d;
  logic [4:0]  ip_off_d;
  logic        udp_d;
  logic [6:0]  udp_off_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  // A byte that ends no frame can move on even while a result waits.
  assign s1_go      = s1_valid_q && (!s1_last_q || out_ready);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign res_load   = s1_go && s1_last_q;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_go);

  always_comb begin
    cap_outer   = outer_q;
    cap_inner   = inner_q;
    cap_vlan    = vlan_q;
    cap_ver_ihl = ver_ihl_q;
    cap_totlen  = totlen_q;
    cap_proto   = proto_q;
    hdr_off     = {11'd0, (vlan_q ? evic_pkg::OFF_VLAN : evic_pkg::OFF_PLAIN)};
    rel         = idx_q - hdr_off;

    if (idx_q == evic_pkg::POS_OUTER_HI) begin
      cap_outer = {s1_byte_q, outer_q[7:0]};
    end
    if (idx_q == evic_pkg::POS_OUTER_LO) begin
      cap_outer = {outer_q[15:8], s1_byte_q};
      cap_vlan  = ({outer_q[15:8], s1_byte_q} == evic_pkg::ETYPE_VLAN);
    end
    if (idx_q == evic_pkg::POS_INNER_HI) begin
      cap_inner = {s1_byte_q, inner_q[7:0]};
    end
    if (idx_q == evic_pkg::POS_INNER_LO) begin
      cap_inner = {inner_q[15:8], s1_byte_q};
    end
    // The IP header offset is at least 14, so below it no IP field is taken.
    if (idx_q >= hdr_off) begin
      if (rel == 16'd0) begin
        cap_ver_ihl = s1_byte_q;
      end
      if (rel == evic_pkg::REL_TOTLEN_HI) begin
        cap_totlen = {s1_byte_q, totlen_q[7:0]};
      end
      if (rel == evic_pkg::REL_TOTLEN_LO) begin
        cap_totlen = {totlen_q[15:8], s1_byte_q};
      end
      if (rel == evic_pkg::REL_PROTO) begin
        cap_proto = s1_byte_q;
      end
    end
  end

  always_comb begin
    n        = {1'b0, idx_q} + 17'd1;
    ihl      = cap_ver_ihl[3:0];
    ver      = cap_ver_ihl[7:4];
    ihl_x4   = {10'd0, ihl, 2'b00};
    eval_off = (cap_outer == evic_pkg::ETYPE_VLAN) ? evic_pkg::OFF_VLAN : evic_pkg::OFF_PLAIN;
    room     = s1_cap_q - {11'd0, eval_off};

    if (s1_wire_q != s1_cap_q) begin
      status_d = evic_pkg::ST_LEN_MISMATCH;
    end else if (n < evic_pkg::ETH_HDR_LEN) begin
      status_d = evic_pkg::ST_NOT_IPV4;
    end else if (cap_outer == evic_pkg::ETYPE_VLAN &&
                 (n < evic_pkg::VLAN_HDR_END || cap_inner != evic_pkg::ETYPE_IPV4)) begin
      status_d = evic_pkg::ST_NOT_IPV4;
    end else if (cap_outer != evic_pkg::ETYPE_VLAN && cap_outer != evic_pkg::ETYPE_IPV4) begin
      status_d = evic_pkg::ST_NOT_IPV4;
    end else if (n < {12'd0, eval_off} + evic_pkg::IP_HDR_MIN) begin
      status_d = evic_pkg::ST_BAD_IP;
    end else if (ver != evic_pkg::IP_VERSION || ihl < evic_pkg::MIN_IHL) begin
      status_d = evic_pkg::ST_BAD_IP;
    end else if (s1_cap_q < {11'd0, eval_off}) begin
      status_d = evic_pkg::ST_BAD_IP;
    end else if (ihl_x4 > room || cap_totlen > room) begin
      status_d = evic_pkg::ST_BAD_IP;
    end else begin
      status_d = evic_pkg::ST_OK;
    end

    ip_off_d  = (status_d == evic_pkg::ST_OK) ? eval_off : 5'd0;
    udp_d     = (status_d == evic_pkg::ST_OK) && (cap_proto == evic_pkg::PROTO_UDP);
    udp_off_d = udp_d ? ({2'b00, eval_off} + {1'b0, ihl, 2'b00}) : 7'd0;
  end

  always_comb begin
    idx_d     = idx_q;
    outer_d   = outer_q;
    inner_d   = inner_q;
    vlan_d    = vlan_q;
    ver_ihl_d = ver_ihl_q;
    totlen_d  = totlen_q;
    proto_d   = proto_q;
    if (s1_go) begin
      if (s1_last_q) begin
        idx_d     = 16'd0;
        outer_d   = 16'd0;
        inner_d   = 16'd0;
        vlan_d    = 1'b0;
        ver_ihl_d = 8'd0;
        totlen_d  = 16'd0;
        proto_d   = 8'd0;
      end else begin
        // The count saturates so that very long frames never alias a header position.
        idx_d     = (idx_q == evic_pkg::IDX_MAX) ? idx_q : idx_q + 16'd1;
        outer_d   = cap_outer;
        inner_d   = cap_inner;
        vlan_d    = cap_vlan;
        ver_ihl_d = cap_ver_ihl;
        totlen_d  = cap_totlen;
        proto_d   = cap_proto;
      end
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 16'd0;
      outer_q     <= 16'd0;
      inner_q     <= 16'd0;
      vlan_q      <= 1'b0;
      ver_ihl_q   <= 8'd0;
      totlen_q    <= 16'd0;
      proto_q     <= 8'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      outer_q     <= outer_d;
      inner_q     <= inner_d;
      vlan_q      <= vlan_d;
      ver_ihl_q   <= ver_ihl_d;
      totlen_q    <= totlen_d;
      proto_q     <= proto_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= pkt_byte_i;
      s1_last_q <= last_byte_i;
      s1_cap_q  <= cap_len_i;
      s1_wire_q <= wire_len_i;
    end
    if (res_load) begin
      status_q  <= status_d;
      ip_off_q  <= ip_off_d;
      udp_q     <= udp_d;
      udp_off_q <= udp_off_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign ip_offset_o  = ip_off_q;
  assign is_udp_o     = udp_q;
  assign udp_offset_o = udp_off_q;

endmodule

>>> sv/evic_checker.sv
// Port-level assertions for the Ethernet/VLAN/IPv4 header checker, and their bind.
// Depends on evic_pkg and on eth_vlan_ipv4_header_checker_defines.svh.
`timescale 1ns / 1ps
`include "eth_vlan_ipv4_header_checker_defines.svh"

module evic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  pkt_byte_i,
  input logic        last_byte_i,
  input logic [15:0] cap_len_i,
  input logic [15:0] wire_len_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [4:0]  ip_offset_o,
  input logic        is_udp_o,
  input logic [6:0]  udp_offset_o
);

  logic res_ok;
  logic res_held;

  assign res_ok   = out_valid_o && (status_o == evic_pkg::ST_OK);
  assign res_held = out_valid_o && out_stall_i;

  // A result held back by the receiver stays valid, with its status and both offsets unchanged.
  `EVIC_ASSERT_NEXT(a_held_result, clk_i, rst_ni, res_held, out_valid_o && $stable(status_o) && $stable(ip_offset_o) && $stable(udp_offset_o))

  // A failed check reports no offsets and no UDP.
  `EVIC_ASSERT_SAME(a_err_zero, clk_i, rst_ni, out_valid_o && !res_ok, ip_offset_o == 5'd0 && !is_udp_o && udp_offset_o == 7'd0)

  // A good frame has its IP header right after an untagged or a tagged Ethernet header.
  `EVIC_ASSERT_SAME(a_ok_offset, clk_i, rst_ni, res_ok, ip_offset_o == evic_pkg::OFF_PLAIN || ip_offset_o == evic_pkg::OFF_VLAN)

  // The UDP header starts at least a minimal IP header past the IP offset.
  `EVIC_ASSERT_SAME(a_udp_offset, clk_i, rst_ni, out_valid_o && is_udp_o, res_ok && udp_offset_o >= {2'b00, ip_offset_o} + 7'd20 && udp_offset_o <= {2'b00, ip_offset_o} + 7'd60)

  // Without UDP there is no UDP offset.
  `EVIC_ASSERT_SAME(a_no_udp, clk_i, rst_ni, out_valid_o && !is_udp_o, udp_offset_o == 7'd0)

endmodule

bind eth_vlan_ipv4_header_checker evic_checker u_evic_checker (.*);
